>>> src/lwae_pkg.sv
package lwae_pkg;

	// Depth of the sample history ring.
	localparam int unsigned DEPTH = 128;

	localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Wide enough to hold a count from 0 up to DEPTH.
	localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

	localparam int unsigned TIME_W  = 24;
	localparam int unsigned WLEN_W  = 8;
	localparam int unsigned MW_W    = 24;
	localparam int unsigned STEP_W  = 16;
	localparam int unsigned USED_W  = 8;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned CDATA_W = 24;

	localparam int unsigned PROD_W  = TIME_W + MW_W;
	localparam int unsigned SUM_W   = PROD_W + CNT_W;
	localparam int unsigned TOT_W   = MW_W + CNT_W;
	localparam int unsigned DEC_W   = MW_W + CNT_W;
	// The average never exceeds the largest sample, so the quotient fits TIME_W bits.
	localparam int unsigned QUO_W   = TIME_W;
	localparam int unsigned DCNT_W  = $clog2(QUO_W + 1);
	// Sample time scaled by 60 needs six more bits.
	localparam int unsigned HOUR_W  = TIME_W + 6;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic [WLEN_W-1:0] WINDOW_LEN_RST  = 8'd120;
	localparam logic [MW_W-1:0]   MAX_WEIGHT_RST  = 24'd163840;
	localparam logic [STEP_W-1:0] WEIGHT_STEP_RST = 16'd819;

	typedef enum logic [CIDX_W-1:0] {
		REG_WINDOW_LEN  = 2'd0,
		REG_MAX_WEIGHT  = 2'd1,
		REG_WEIGHT_STEP = 2'd2
	} reg_idx_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEW,
		ST_RD,
		ST_MUL,
		ST_FIN,
		ST_DIVINIT,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

>>> src/lwae_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module lwae_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 128
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/linear_weighted_average_estimator.sv
// Channel   Direction  Handshake                     Word
// sample    in         sample_valid / sample_stall   cmd, sample_time, unit_is_hours
// result    out        result_valid / result_stall   average_minutes, samples_used
// cfg       in         cfg_valid / cfg_ready         cfg_index, cfg_data
//
// A sample word walks the stored samples in use (at most 128, reached with a window
// above the ring depth); a zero total weight skips the 24 divide steps. The single
// multiplier and the one-bit-per-cycle divider are walked by the sequencer. A clear
// word empties the history and leaves the sequencer idle.
// Reset (arst_n low) loads the register defaults and empties the history.
// sample_stall is high whenever the sequencer is busy; a finished result
// waits in the output register, and the next word is taken while it waits.
module linear_weighted_average_estimator (
	input  logic                          clk,
	input  logic                          arst_n,
	// Sample channel
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic                          cmd,
	input  logic [lwae_pkg::TIME_W-1:0]   sample_time,
	input  logic                          unit_is_hours,
	// Result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [lwae_pkg::TIME_W-1:0]   average_minutes,
	output logic [lwae_pkg::USED_W-1:0]   samples_used,
	// Configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lwae_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [lwae_pkg::CDATA_W-1:0]  cfg_data
);

	// Configuration registers.
	logic [lwae_pkg::WLEN_W-1:0] window_len_q;
	logic [lwae_pkg::MW_W-1:0]   max_weight_q;
	logic [lwae_pkg::STEP_W-1:0] weight_step_q;

	// History ring bookkeeping. The newest stored sample sits at newest_q and
	// older ones follow at increasing addresses, wrapping at the ring depth.
	logic [lwae_pkg::CNT_W-1:0]  hist_count_q;
	logic [lwae_pkg::ADDR_W-1:0] newest_q;

	// Per-word working registers.
	lwae_pkg::state_t            state_q, state_d;
	logic [lwae_pkg::TIME_W-1:0] t_q;
	logic [lwae_pkg::CNT_W-1:0]  used_q;
	logic [lwae_pkg::CNT_W-1:0]  cap_q;
	logic [lwae_pkg::CNT_W-1:0]  i_q;
	logic [lwae_pkg::DEC_W-1:0]  dec_q;
	logic [lwae_pkg::ADDR_W-1:0] pos_q;
	logic [lwae_pkg::PROD_W-1:0] prod_q;
	logic [lwae_pkg::SUM_W-1:0]  sum_q;
	logic [lwae_pkg::TOT_W-1:0]  total_q;
	logic [lwae_pkg::TOT_W-1:0]  rem_q;
	logic [lwae_pkg::QUO_W-1:0]  quo_q;
	logic [lwae_pkg::DCNT_W-1:0] div_cnt_q;

	// Output register.
	logic                        res_valid_q;
	logic [lwae_pkg::TIME_W-1:0] res_avg_q;
	logic [lwae_pkg::USED_W-1:0] res_used_q;

	logic                        sample_take;
	logic                        res_free;
	logic [lwae_pkg::HOUR_W-1:0] t_hours;
	logic [lwae_pkg::TIME_W-1:0] t_min;
	logic [15:0]                 wl_m1;
	logic [lwae_pkg::CNT_W-1:0]  cap_now;
	logic [lwae_pkg::CNT_W-1:0]  used_now;
	logic [lwae_pkg::MW_W-1:0]   weight;
	logic [lwae_pkg::TIME_W-1:0] mul_a;
	logic [lwae_pkg::MW_W-1:0]   mul_b;
	logic [lwae_pkg::PROD_W-1:0] mul_p;
	logic [lwae_pkg::SUM_W-1:0]  num;
	logic [lwae_pkg::TOT_W:0]    trial;
	logic                        trial_ge;
	logic [lwae_pkg::TOT_W:0]    trial_diff;
	logic [lwae_pkg::ADDR_W-1:0] push_addr;
	logic [lwae_pkg::CNT_W:0]    used_p1;
	logic [lwae_pkg::CNT_W-1:0]  count_next;
	logic [15:0]                 used_out;
	logic                        push_we;
	logic [lwae_pkg::TIME_W-1:0] ram_rdata;

	assign sample_take = sample_valid && !sample_stall;
	assign res_free    = !res_valid_q || !result_stall;

	assign cfg_ready       = 1'b1;
	assign result_valid    = res_valid_q;
	assign average_minutes = res_avg_q;
	assign samples_used    = res_used_q;

	// Hours are scaled by 60 as (t << 6) - (t << 2) and saturated.
	assign t_hours = {sample_time, 6'd0} - {4'd0, sample_time, 2'd0};
	always_comb begin
		if (!unit_is_hours) begin
			t_min = sample_time;
		end else if (t_hours > lwae_pkg::HOUR_W'(lwae_pkg::TIME_MAX)) begin
			t_min = lwae_pkg::TIME_MAX;
		end else begin
			t_min = t_hours[lwae_pkg::TIME_W-1:0];
		end
	end

	// History capacity is window_len - 1, floored at zero and capped at the depth.
	assign wl_m1 = (window_len_q == '0) ? 16'd0 : (16'(window_len_q) - 16'd1);
	assign cap_now = (wl_m1 > 16'(lwae_pkg::DEPTH)) ? lwae_pkg::CNT_W'(lwae_pkg::DEPTH)
		: lwae_pkg::CNT_W'(wl_m1);
	assign used_now = (hist_count_q > cap_now) ? cap_now : hist_count_q;

	// Weight of the stored sample at the current age, clamped at zero.
	assign weight = (dec_q >= lwae_pkg::DEC_W'(max_weight_q)) ? '0
		: (max_weight_q - dec_q[lwae_pkg::MW_W-1:0]);

	// The one multiplier serves both the newest sample and every stored sample.
	assign mul_a = (state_q == lwae_pkg::ST_NEW) ? t_q : ram_rdata;
	assign mul_b = (state_q == lwae_pkg::ST_NEW) ? max_weight_q : weight;
	assign mul_p = lwae_pkg::PROD_W'(mul_a) * lwae_pkg::PROD_W'(mul_b);

	// Rounded division numerator; it stays below total * 2^24, so it fits.
	assign num = sum_q + lwae_pkg::SUM_W'(total_q >> 1);

	// One restoring divide step.
	assign trial      = {rem_q, quo_q[lwae_pkg::QUO_W-1]};
	assign trial_ge   = trial >= {1'b0, total_q};
	assign trial_diff = trial - {1'b0, total_q};

	assign push_addr  = (newest_q == '0) ? lwae_pkg::ADDR_W'(lwae_pkg::DEPTH - 1)
		: (newest_q - lwae_pkg::ADDR_W'(1));
	assign used_p1    = {1'b0, used_q} + (lwae_pkg::CNT_W + 1)'(1);
	assign count_next = (used_p1 > {1'b0, cap_q}) ? cap_q : used_p1[lwae_pkg::CNT_W-1:0];
	assign used_out   = 16'(used_q) + 16'd1;
	assign push_we    = (state_q == lwae_pkg::ST_DONE) && res_free && (cap_q != '0);

	lwae_ram #(
		.WIDTH(lwae_pkg::TIME_W),
		.DEPTH(lwae_pkg::DEPTH)
	) u_hist_ram (
		.clk  (clk),
		.we   (push_we),
		.waddr(push_addr),
		.wdata(t_q),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	// Sequencer next state and the sample-side stall.
	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		case (state_q)
			lwae_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid && (cmd == lwae_pkg::CMD_SAMPLE)) begin
					state_d = lwae_pkg::ST_NEW;
				end
			end
			lwae_pkg::ST_NEW: begin
				state_d = (used_q == '0) ? lwae_pkg::ST_FIN : lwae_pkg::ST_RD;
			end
			lwae_pkg::ST_RD: begin
				state_d = lwae_pkg::ST_MUL;
			end
			lwae_pkg::ST_MUL: begin
				state_d = (i_q == used_q) ? lwae_pkg::ST_FIN : lwae_pkg::ST_RD;
			end
			lwae_pkg::ST_FIN: begin
				state_d = lwae_pkg::ST_DIVINIT;
			end
			lwae_pkg::ST_DIVINIT: begin
				state_d = (total_q == '0) ? lwae_pkg::ST_DONE : lwae_pkg::ST_DIV;
			end
			lwae_pkg::ST_DIV: begin
				if (div_cnt_q == lwae_pkg::DCNT_W'(lwae_pkg::QUO_W - 1)) begin
					state_d = lwae_pkg::ST_DONE;
				end
			end
			lwae_pkg::ST_DONE: begin
				if (res_free) begin
					state_d = lwae_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lwae_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lwae_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q  <= lwae_pkg::WINDOW_LEN_RST;
			max_weight_q  <= lwae_pkg::MAX_WEIGHT_RST;
			weight_step_q <= lwae_pkg::WEIGHT_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lwae_pkg::REG_WINDOW_LEN:  window_len_q  <= cfg_data[lwae_pkg::WLEN_W-1:0];
				lwae_pkg::REG_MAX_WEIGHT:  max_weight_q  <= cfg_data[lwae_pkg::MW_W-1:0];
				lwae_pkg::REG_WEIGHT_STEP: weight_step_q <= cfg_data[lwae_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// History bookkeeping and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_count_q <= '0;
			newest_q     <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (sample_take && (cmd == lwae_pkg::CMD_CLEAR)) begin
				hist_count_q <= '0;
			end
			if ((state_q == lwae_pkg::ST_DONE) && res_free) begin
				res_valid_q <= 1'b1;
				if (cap_q != '0) begin
					newest_q     <= push_addr;
					hist_count_q <= count_next;
				end else begin
					hist_count_q <= '0;
				end
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			lwae_pkg::ST_IDLE: begin
				t_q    <= t_min;
				cap_q  <= cap_now;
				used_q <= used_now;
			end
			lwae_pkg::ST_NEW: begin
				prod_q  <= mul_p;
				sum_q   <= '0;
				total_q <= lwae_pkg::TOT_W'(max_weight_q);
				i_q     <= lwae_pkg::CNT_W'(1);
				dec_q   <= lwae_pkg::DEC_W'(weight_step_q);
				pos_q   <= newest_q;
			end
			lwae_pkg::ST_RD: begin
				sum_q <= sum_q + lwae_pkg::SUM_W'(prod_q);
			end
			lwae_pkg::ST_MUL: begin
				prod_q  <= mul_p;
				total_q <= total_q + lwae_pkg::TOT_W'(weight);
				dec_q   <= dec_q + lwae_pkg::DEC_W'(weight_step_q);
				i_q     <= i_q + lwae_pkg::CNT_W'(1);
				pos_q   <= (pos_q == lwae_pkg::ADDR_W'(lwae_pkg::DEPTH - 1)) ? '0
					: (pos_q + lwae_pkg::ADDR_W'(1));
			end
			lwae_pkg::ST_FIN: begin
				sum_q <= sum_q + lwae_pkg::SUM_W'(prod_q);
			end
			lwae_pkg::ST_DIVINIT: begin
				rem_q     <= num[lwae_pkg::SUM_W-1:lwae_pkg::QUO_W];
				quo_q     <= num[lwae_pkg::QUO_W-1:0];
				div_cnt_q <= '0;
			end
			lwae_pkg::ST_DIV: begin
				rem_q     <= trial_ge ? trial_diff[lwae_pkg::TOT_W-1:0]
					: trial[lwae_pkg::TOT_W-1:0];
				quo_q     <= {quo_q[lwae_pkg::QUO_W-2:0], trial_ge};
				div_cnt_q <= div_cnt_q + lwae_pkg::DCNT_W'(1);
			end
			lwae_pkg::ST_DONE: begin
				if (res_free) begin
					// A zero total weight means the average is the newest sample.
					res_avg_q  <= (total_q == '0) ? t_q : quo_q;
					res_used_q <= used_out[lwae_pkg::USED_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// The partial remainder stays below the divisor throughout the divide.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lwae_pkg::ST_DIV) |-> (rem_q < total_q))
		else $error("divider remainder not below divisor");

	// The stored count never exceeds the ring depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		hist_count_q <= lwae_pkg::CNT_W'(lwae_pkg::DEPTH))
		else $error("history count beyond ring depth");

	// A sample word starts the sequencer on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(sample_take && (cmd == lwae_pkg::CMD_SAMPLE)) |=> (state_q == lwae_pkg::ST_NEW))
		else $error("sample word did not start the sequencer");

	// The walk over stored samples never goes past the samples in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lwae_pkg::ST_MUL) |-> ((i_q <= used_q) && (i_q != '0)))
		else $error("history walk out of range");

	// A new result is loaded only when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && result_stall && (state_q == lwae_pkg::ST_DONE))
			|=> (state_q == lwae_pkg::ST_DONE))
		else $error("result overwritten while stalled");

endmodule
